FILE: hdl/tlv_parameter_block_parser_assert.svh
// Assertion macros used by the parameter block parser checker.
`ifndef TLV_PARAMETER_BLOCK_PARSER_ASSERT_SVH
`define TLV_PARAMETER_BLOCK_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TLVP_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("tlvp assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TLVP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("tlvp assertion failed");

`endif

FILE: hdl/tlvp_pkg.sv
// Types and constants of the parameter block parser.
package tlvp_pkg;

   localparam int LEN_W           = 21;
   localparam int MAX_BLOCK_BYTES = 1048576;

   localparam logic [7:0]  VERSION_FLAGS = 8'hC;
   localparam logic [31:0] FLAG_MORE     = 32'h8000_0000;
   localparam int          FLAG_GZIP_BIT = 0;
   localparam int          FLAG_MAY_BIT  = 1;

   // Parser phase
   typedef enum logic [2:0] {
      PH_START,
      PH_FLAGS,
      PH_NEXT,
      PH_HDR,
      PH_VALUE,
      PH_COMP,
      PH_SKIP
   } phase_type;

   // Classification of each byte
   typedef enum logic [2:0] {
      KIND_FLAGS,
      KIND_HDR,
      KIND_VALUE,
      KIND_COMP,
      KIND_SKIP
   } byte_kind_type;

   typedef struct packed {
      logic [7:0]       byte_value;
      logic [LEN_W-1:0] block_length;
   } req_payload_type;

   typedef struct packed {
      byte_kind_type byte_kind;
      logic [15:0]   param_id;
      logic [15:0]   param_length;
      logic          param_start;
      logic [7:0]    value_byte;
      logic [15:0]   value_offset;
      logic          value_last;
      logic          end_of_block;
      logic          block_valid;
      logic          may_compress;
   } rsp_payload_type;

endpackage

FILE: hdl/tlv_parameter_block_parser.sv
// Streaming parser for parameter blocks of 16-bit TLV records, one byte per item.
// An accepted item's result appears in the output register in the next cycle.
// Throughput: one item per cycle; the per-byte state update is a single pass of
// counter and compare logic, and the output register is the only stall point.
// Reset (synchronous, active high): protocol version 0, parser at start of block.
module tlv_parameter_block_parser
   import tlvp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [7:0]      csr_data
);

   logic [7:0]       version_ff;
   logic [LEN_W-1:0] pos_ff, pos_in;
   phase_type        phase_ff, phase_in;
   logic [31:0]      hw_ff, hw_in;
   logic [15:0]      id_ff, id_in;
   logic [15:0]      len_ff, len_in;
   logic [15:0]      vc_ff, vc_in;
   logic             vf_ff, vf_in;
   logic [1:0]       ff_ff, ff_in;

   logic             rsp_valid_ff;
   rsp_payload_type  rsp_ff, rsp_in;

   logic             accept;
   logic [LEN_W-1:0] blen;
   logic [LEN_W+1:0] npos;
   logic [16:0]      vc_sum;
   logic [31:0]      word;
   logic [7:0]       b;

   // Output register handshake: stall only while a result waits
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign accept      = req_valid & ~req_stall;
   assign csr_ready   = 1'b1;

   // Per-byte parse step
   always_comb begin
      b    = req_payload.byte_value;
      blen = req_payload.block_length;
      if (blen == '0) begin
         blen = LEN_W'(1);
      end
      if (32'(blen) > 32'(MAX_BLOCK_BYTES)) begin
         blen = LEN_W'(MAX_BLOCK_BYTES);
      end
      npos   = (LEN_W+2)'(pos_ff) + (LEN_W+2)'(1);
      vc_sum = '0;
      word   = '0;

      phase_in = phase_ff;
      hw_in    = hw_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      vc_in    = vc_ff;
      vf_in    = vf_ff;
      ff_in    = ff_ff;
      pos_in   = pos_ff;

      rsp_in              = '0;
      rsp_in.byte_kind    = KIND_SKIP;

      // New block: clear per-block state
      if (phase_ff == PH_START) begin
         hw_in  = '0;
         id_in  = '0;
         len_in = '0;
         vc_in  = '0;
         vf_in  = 1'b1;
         ff_in  = '0;
         phase_in = (version_ff >= VERSION_FLAGS && 32'(blen) >= 32'd4) ?
                    PH_FLAGS : PH_NEXT;
      end
      // Between records: room for a header or a trailing-byte error
      if (phase_in == PH_NEXT) begin
         if ((LEN_W+2)'(pos_ff) + (LEN_W+2)'(4) <= (LEN_W+2)'(blen)) begin
            phase_in = PH_HDR;
            vc_in    = '0;
            id_in    = '0;
            len_in   = '0;
         end else begin
            vf_in    = 1'b0;
            phase_in = PH_SKIP;
         end
      end

      case (phase_in)
         PH_FLAGS: begin
            rsp_in.byte_kind = KIND_FLAGS;
            word   = {hw_in[23:0], b};
            vc_sum = 17'(vc_in) + 17'd1;
            vc_in  = vc_sum[15:0];
            hw_in  = word;
            if (vc_sum[15:0] >= 16'd4) begin
               vc_in = '0;
               hw_in = '0;
               if (pos_ff < LEN_W'(4)) begin
                  ff_in = word[1:0];
               end
               if ((word & FLAG_MORE) != '0 &&
                   npos + (LEN_W+2)'(4) <= (LEN_W+2)'(blen)) begin
                  phase_in = PH_FLAGS;
               end else if (ff_in[FLAG_GZIP_BIT]) begin
                  phase_in = PH_COMP;
               end else begin
                  phase_in = PH_NEXT;
               end
            end
         end
         PH_HDR: begin
            rsp_in.byte_kind = KIND_HDR;
            case (vc_in[1:0])
               2'd0:    id_in  = {b, 8'h00};
               2'd1:    id_in  = id_in | {8'h00, b};
               2'd2:    len_in = {b, 8'h00};
               default: len_in = len_in | {8'h00, b};
            endcase
            rsp_in.param_id     = id_in;
            rsp_in.param_length = len_in;
            vc_sum = 17'(vc_in) + 17'd1;
            vc_in  = vc_sum[15:0];
            if (vc_sum[15:0] >= 16'd4) begin
               vc_in = '0;
               if (npos + (LEN_W+2)'(len_in) <= (LEN_W+2)'(blen)) begin
                  rsp_in.param_start = 1'b1;
                  phase_in = (len_in != '0) ? PH_VALUE : PH_NEXT;
               end else begin
                  vf_in    = 1'b0;
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_VALUE: begin
            rsp_in.byte_kind    = KIND_VALUE;
            rsp_in.param_id     = id_in;
            rsp_in.param_length = len_in;
            rsp_in.value_byte   = b;
            rsp_in.value_offset = vc_in;
            vc_sum = 17'(vc_in) + 17'd1;
            rsp_in.value_last = (vc_sum >= 17'(len_in));
            vc_in = vc_sum[15:0];
            if (rsp_in.value_last) begin
               vc_in    = '0;
               phase_in = PH_NEXT;
            end
         end
         PH_COMP: begin
            rsp_in.byte_kind = KIND_COMP;
         end
         default: begin
            rsp_in.byte_kind = KIND_SKIP;
         end
      endcase

      // Block end
      rsp_in.end_of_block = (npos >= (LEN_W+2)'(blen));
      if (rsp_in.end_of_block) begin
         pos_in   = '0;
         phase_in = PH_START;
      end else begin
         pos_in = npos[LEN_W-1:0];
      end
      rsp_in.block_valid  = vf_in;
      rsp_in.may_compress = ff_in[FLAG_MAY_BIT];
   end

   // Parser state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= '0;
         pos_ff     <= '0;
         phase_ff   <= PH_START;
         hw_ff      <= '0;
         id_ff      <= '0;
         len_ff     <= '0;
         vc_ff      <= '0;
         vf_ff      <= 1'b1;
         ff_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            version_ff <= csr_data;
         end
         if (accept) begin
            pos_ff   <= pos_in;
            phase_ff <= phase_in;
            hw_ff    <= hw_in;
            id_ff    <= id_in;
            len_ff   <= len_in;
            vc_ff    <= vc_in;
            vf_ff    <= vf_in;
            ff_ff    <= ff_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: hdl/tlvp_checker.sv
// Port-level checks of the parameter block parser, bound to its top level.
`include "tlv_parameter_block_parser_assert.svh"

module tlvp_checker
   import tlvp_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // Value fields are zero on anything but a value byte
   `TLVP_ASSERT_IMPLIES(a_value_fields, clock, reset, rsp_valid && rsp_payload.byte_kind != KIND_VALUE, rsp_payload.value_byte == '0 && rsp_payload.value_offset == '0 && !rsp_payload.value_last)

   // Record start only on a header byte
   `TLVP_ASSERT_IMPLIES(a_start_on_hdr, clock, reset, rsp_valid && rsp_payload.param_start, rsp_payload.byte_kind == KIND_HDR)

   // Last value byte sits at offset length minus one
   `TLVP_ASSERT_IMPLIES(a_last_offset, clock, reset, rsp_valid && rsp_payload.value_last, 17'(rsp_payload.value_offset) + 17'd1 >= 17'(rsp_payload.param_length))

   // Input is held back only while a result waits
   `TLVP_ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // A stalled result holds
   `TLVP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind tlv_parameter_block_parser tlvp_checker u_tlvp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
